[design/linear_probe_hash_table_top_defines.svh]
// Assertion macros shared by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lpht_pkg.sv]
// Shared types and constants of the linear probing hash table.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

   localparam int TABLE_SIZE_DEF = 64;
   localparam int KEY_BYTES_DEF  = 8;
   localparam int VALUE_BITS_DEF = 32;

   // Q0.32 golden ratio fraction and per-byte multiplier of the string hash
   localparam logic [31:0] GOLDEN_Q32 = 32'h9E3779B9;
   localparam logic [31:0] HASH_MUL   = 32'd37;

   // Operation codes
   localparam logic [1:0] FUNC_PUT    = 2'd0;
   localparam logic [1:0] FUNC_GET    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // What the slot state memory is written with
   typedef enum logic [1:0] {
      STW_CLEAR,
      STW_FILL,
      STW_KILL
   } stw_type;

   typedef struct packed {
      logic present;
      logic tomb;
   } slot_state_type;

   typedef struct packed {
      logic    load;
      logic    hash_step;
      logic    hash_final;
      logic    set_home;
      logic    advance;
      logic    status_we;
      stw_type status_sel;
      logic    entry_we;
      logic    res_hit;
      logic    rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       hash_done;
      logic       present;
      logic       tomb;
      logic       key_match;
      logic       probe_last;
      logic       clear_last;
   } stat_type;

endpackage

`default_nettype wire

[design/lpht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/lpht_ctrl.sv]
// Controller state machine: sequences clearing, hashing, probing and result transfer.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  lpht_pkg::stat_type stat,
   output lpht_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_FINAL,
      ST_HOME,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.status_we  = 1'b1;
            cmd.status_sel = lpht_pkg::STW_CLEAR;
            cmd.advance    = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (stat.func == lpht_pkg::FUNC_NONE) begin
               state_in = ST_DONE;
            end else if (stat.hash_done) begin
               state_in = ST_FINAL;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         ST_FINAL: begin
            cmd.hash_final = 1'b1;
            state_in       = ST_HOME;
         end
         ST_HOME: begin
            cmd.set_home = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.func == lpht_pkg::FUNC_PUT) begin
               if (!stat.present) begin
                  cmd.status_we  = 1'b1;
                  cmd.status_sel = lpht_pkg::STW_FILL;
                  cmd.entry_we   = 1'b1;
                  cmd.res_hit    = 1'b1;
                  state_in       = ST_DONE;
               end else if (stat.probe_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end else begin
               if (!stat.present && !stat.tomb) begin
                  state_in = ST_DONE;
               end else if (stat.present && stat.key_match) begin
                  cmd.res_hit = 1'b1;
                  if (stat.func == lpht_pkg::FUNC_REMOVE) begin
                     cmd.status_we  = 1'b1;
                     cmd.status_sel = lpht_pkg::STW_KILL;
                  end
                  state_in = ST_DONE;
               end else if (stat.probe_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[design/lpht_dp.sv]
// Datapath: key normalization, string hash, probe pointer, table memories and result registers.
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BYTES  = lpht_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  lpht_pkg::cmd_type  cmd,
   output lpht_pkg::stat_type stat,
   input  logic [1:0]         req_func,
   input  logic [63:0]        req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_ok,
   output logic [5:0]         rsp_slot,
   output logic signed [31:0] rsp_found_value
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int BC_W  = $clog2(KEY_BYTES + 1);
   localparam int ENT_W = KEY_W + VALUE_BITS;

   logic [1:0]         func_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   shift_ff;
   logic signed [31:0] val_ff;
   logic [31:0]        t_ff;
   logic [BC_W-1:0]    byte_cnt_ff;
   logic [IDX_W-1:0]   j_ff;
   logic [IDX_W-1:0]   n_ff;
   logic               res_ok_ff;
   logic [IDX_W-1:0]   res_slot_ff;
   logic [31:0]        res_fv_ff;
   logic               rsp_ok_ff;
   logic [5:0]         rsp_slot_ff;
   logic [31:0]        rsp_fv_ff;

   logic [KEY_W-1:0]   norm_key;
   logic [31:0]        t_step;
   logic [63:0]        home_prod;
   logic [IDX_W-1:0]   j_next;
   logic [63:0]        val_sx;
   logic [63:0]        fv_wide;

   lpht_pkg::slot_state_type st_wr;
   lpht_pkg::slot_state_type st_rd;
   logic [ENT_W-1:0]   ent_rd;

   // Keep bytes up to the first zero byte, zero the rest
   always_comb begin
      logic alive;
      alive    = 1'b1;
      norm_key = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (req_key[8*i +: 8] == 8'd0) begin
            alive = 1'b0;
         end
         if (alive) begin
            norm_key[8*i +: 8] = req_key[8*i +: 8];
         end
      end
   end

   assign t_step    = 32'(t_ff * lpht_pkg::HASH_MUL)
                    + 32'({24'd0, shift_ff[7:0]} * lpht_pkg::GOLDEN_Q32);
   assign home_prod = 64'(t_ff) * 64'(TABLE_SIZE);
   assign j_next    = (j_ff == IDX_W'(TABLE_SIZE - 1)) ? '0 : j_ff + 1'b1;
   assign val_sx    = 64'(val_ff);

   always_comb begin
      case (cmd.status_sel)
         lpht_pkg::STW_FILL: st_wr = '{present: 1'b1, tomb: 1'b0};
         lpht_pkg::STW_KILL: st_wr = '{present: 1'b0, tomb: 1'b1};
         default:            st_wr = '{present: 1'b0, tomb: 1'b0};
      endcase
   end

   lpht_ram #(
      .WIDTH ($bits(lpht_pkg::slot_state_type)),
      .DEPTH (TABLE_SIZE)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (cmd.status_we),
      .wr_addr (j_ff),
      .wr_data (st_wr),
      .rd_addr (j_ff),
      .rd_data (st_rd)
   );

   lpht_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.entry_we),
      .wr_addr (j_ff),
      .wr_data ({key_ff, VALUE_BITS'(val_sx)}),
      .rd_addr (j_ff),
      .rd_data (ent_rd)
   );

   assign fv_wide = 64'(ent_rd[VALUE_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else if (cmd.set_home) begin
         j_ff <= IDX_W'(home_prod >> 32);
      end else if (cmd.advance) begin
         j_ff <= j_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= req_func;
         key_ff      <= norm_key;
         shift_ff    <= norm_key;
         val_ff      <= req_value;
         t_ff        <= '0;
         byte_cnt_ff <= '0;
         res_ok_ff   <= 1'b0;
         res_slot_ff <= '0;
         res_fv_ff   <= '0;
      end else begin
         if (cmd.hash_step) begin
            t_ff        <= t_step;
            shift_ff    <= shift_ff >> 8;
            byte_cnt_ff <= byte_cnt_ff + 1'b1;
         end else if (cmd.hash_final) begin
            t_ff <= 32'(t_ff * lpht_pkg::HASH_MUL);
         end
         if (cmd.res_hit) begin
            res_ok_ff   <= 1'b1;
            res_slot_ff <= j_ff;
            res_fv_ff   <= (func_ff == lpht_pkg::FUNC_GET) ? 32'(fv_wide) : '0;
         end
      end
      if (cmd.set_home) begin
         n_ff <= '0;
      end else if (cmd.advance) begin
         n_ff <= n_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_slot_ff <= 6'(res_slot_ff);
         rsp_fv_ff   <= res_fv_ff;
      end
   end

   assign stat.func       = func_ff;
   assign stat.hash_done  = (byte_cnt_ff == BC_W'(KEY_BYTES)) || (shift_ff[7:0] == 8'd0);
   assign stat.present    = st_rd.present;
   assign stat.tomb       = st_rd.tomb;
   assign stat.key_match  = (ent_rd[ENT_W-1:VALUE_BITS] == key_ff);
   assign stat.probe_last = (n_ff == IDX_W'(TABLE_SIZE - 1));
   assign stat.clear_last = (j_ff == IDX_W'(TABLE_SIZE - 1));

   assign rsp_ok          = rsp_ok_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_found_value = rsp_fv_ff;

endmodule

`default_nettype wire

[design/linear_probe_hash_table_top.sv]
// Top level of the open-addressed hash table with linear probing and tombstones.
// Each request transfer carries a put, get or remove with a key of up to KEY_BYTES bytes
// (first char in the low byte, zero terminated) and a value; each one yields exactly one
// response transfer with ok, the slot used or found, and for a hit on get the stored value.
// The home slot comes from a Q0.32 Fibonacci string hash; put takes the first slot that is
// not present (tombstones are reused, no duplicate check), get and remove stop at a
// never-used slot and skip tombstones. After reset the slot state memory is swept clear,
// one slot a cycle from slot 0 up to slot TABLE_SIZE-1, and no request is taken during
// the sweep. A request then runs through the hash loop, which consumes one key byte per
// cycle and takes one more step to see the end of the key, the final multiply, the home
// slot load, a read step and a check step for each probed slot (the table memories have
// a registered read), and the result load with the return to idle; no new request is
// taken before the block is back in idle. An unused operation code leaves the hash state
// straight for the result load. A finished result waits in an output register,
// so the next request is accepted while the previous response has not been taken yet;
// the block only holds in its result state while that register is still occupied.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_top #(
   parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
   parameter int KEY_BYTES  = lpht_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [63:0]        req_key,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_ok,
   output logic [5:0]         rsp_slot,
   output logic signed [31:0] rsp_found_value
);

`include "linear_probe_hash_table_top_defines.svh"

   // Command and status between the controller and the datapath
   lpht_pkg::cmd_type  cmd;
   lpht_pkg::stat_type stat;

   // Controller: clearing sweep, hash loop, probe loop, response transfer
   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: hash, probe pointer, table memories, response register
   lpht_dp #(
      .TABLE_SIZE (TABLE_SIZE),
      .KEY_BYTES  (KEY_BYTES),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_ok          (rsp_ok),
      .rsp_slot        (rsp_slot),
      .rsp_found_value (rsp_found_value)
   );

   // A miss reports slot and value as zero
   `LPHT_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_ok,
      (rsp_slot == 6'd0) && (rsp_found_value == 32'sd0),
      "miss response carries nonzero slot or value")

   // An entry write only comes with a fill of the slot state
   `LPHT_ASSERT_NOW(a_entry_fill, clock, reset, cmd.entry_we,
      cmd.status_we && (cmd.status_sel == lpht_pkg::STW_FILL),
      "entry written without marking slot present")

   // No table update while idle and open for requests
   `LPHT_ASSERT_NOW(a_idle_quiet, clock, reset, req_ready,
      !cmd.status_we && !cmd.entry_we, "table written while idle")

   // A taken response without a reload drops valid
   `LPHT_ASSERT_NEXT(a_rsp_drop, clock, reset, rsp_valid && rsp_ready && !cmd.rsp_load,
      !rsp_valid, "response repeated after transfer")

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for the linear probing hash table with tombstones.
`timescale 1ns / 1ps

module tb;

   // Hash constants: Q0.32 golden ratio fraction and per-byte multiplier
   localparam bit [31:0] PHI_FRAC     = 32'h9E3779B9;
   localparam bit [31:0] BYTE_MIX     = 32'd37;
   localparam int        SLOTS        = 64;
   localparam int        POOL_SIZE    = 24;
   localparam int        FILL_PUTS    = 70;
   localparam int        IDLE_LIMIT   = 4000;
   localparam int        LONG_HOLD    = 400;
   localparam int        SETTLE_TIME  = 300;

   // Table mirror: predicts each response and queues it until the block answers.
   class shadow_hash_table;
      typedef struct {
         bit        ok;
         bit [5:0]  slot;
         bit [31:0] found_value;
      } lookup_type;

      bit [63:0]  slot_key [SLOTS];
      bit [31:0]  slot_value [SLOTS];
      bit         slot_live [SLOTS];
      bit         slot_dead [SLOTS];
      lookup_type due_results [$];
      int         errors;

      function new();
         foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_dead[i] = 1'b0;
         end
         errors = 0;
      endfunction

      // Keep bytes up to the first zero byte, clear everything above it.
      function bit [63:0] trim_key(bit [63:0] k);
         bit [63:0] r;
         r = '0;
         for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = k[8*i +: 8];
         end
         return r;
      endfunction

      function bit [5:0] home_of(bit [63:0] k);
         bit [31:0] t;
         t = '0;
         if (k[7:0] != 8'd0) begin
            t = {24'd0, k[7:0]} * PHI_FRAC;
            for (int i = 1; i < 8; i++) begin
               if (k[8*i +: 8] == 8'd0) break;
               t = t * BYTE_MIX + {24'd0, k[8*i +: 8]} * PHI_FRAC;
            end
            t = t * BYTE_MIX;
         end
         // floor(t * 64 / 2^32) is the top six bits
         return t[31:26];
      endfunction

      // Walk from home; stop at a never-used slot, step over tombstones.
      function int locate(bit [63:0] k);
         bit [5:0] j;
         j = home_of(k);
         for (int n = 0; n < SLOTS; n++) begin
            if (!slot_live[j] && !slot_dead[j]) return -1;
            if (!slot_dead[j] && slot_key[j] == k) return int'(j);
            j = j + 6'd1;
         end
         return -1;
      endfunction

      function void note_request(bit [1:0] func, bit [63:0] key, bit [31:0] value);
         lookup_type r;
         bit [63:0]  k;
         bit [5:0]   j;
         int         hit;
         r = '{1'b0, 6'd0, 32'd0};
         k = trim_key(key);
         case (func)
            lpht_pkg::FUNC_PUT: begin
               j = home_of(k);
               for (int n = 0; n < SLOTS; n++) begin
                  if (!slot_live[j]) begin
                     slot_live[j]  = 1'b1;
                     slot_dead[j]  = 1'b0;
                     slot_key[j]   = k;
                     slot_value[j] = value;
                     r.ok   = 1'b1;
                     r.slot = j;
                     break;
                  end
                  j = j + 6'd1;
               end
            end
            lpht_pkg::FUNC_GET: begin
               hit = locate(k);
               if (hit >= 0) begin
                  r.ok          = 1'b1;
                  r.slot        = hit[5:0];
                  r.found_value = slot_value[hit];
               end
            end
            lpht_pkg::FUNC_REMOVE: begin
               hit = locate(k);
               if (hit >= 0) begin
                  slot_live[hit] = 1'b0;
                  slot_dead[hit] = 1'b1;
                  r.ok           = 1'b1;
                  r.slot         = hit[5:0];
               end
            end
            default: ;
         endcase
         due_results.push_back(r);
      endfunction

      function void check_response(logic ok, logic [5:0] slot, logic [31:0] found_value);
         lookup_type r;
         if (due_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with nothing outstanding: ok=%0b slot=%0d value=%h",
                        $realtime, ok, slot, found_value);
            return;
         end
         r = due_results.pop_front();
         if (ok !== r.ok || slot !== r.slot || found_value !== r.found_value) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: mismatch: expected ok=%0b slot=%0d value=%h, ",
                         "got ok=%0b slot=%0d value=%h"},
                        $realtime, r.ok, r.slot, r.found_value, ok, slot, found_value);
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_func;
   logic [63:0]        req_key;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_ok;
   logic [5:0]         rsp_slot;
   logic signed [31:0] rsp_found_value;
   logic               long_hold_req;

   shadow_hash_table   table_mirror;
   bit [63:0]          key_pool [POOL_SIZE];
   int                 pool_len [POOL_SIZE];
   bit [63:0]          fill_keys [FILL_PUTS];
   int                 burst_left;

   linear_probe_hash_table_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_slot        (rsp_slot),
      .rsp_found_value (rsp_found_value)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Key and value generation
   // ---------------------------------------------------------------------------

   // A string of len nonzero bytes, zero padded above.
   function automatic bit [63:0] fresh_string(int len);
      bit [63:0] k;
      k = '0;
      for (int i = 0; i < len; i++)
         k[8*i +: 8] = 8'($urandom_range(1, 255));
      return k;
   endfunction

   // Fill the bytes past the terminator with junk half the time; the key must not change.
   function automatic bit [63:0] add_tail(bit [63:0] k, int len);
      if (len <= 6 && $urandom_range(0, 1) == 1)
         k = k | ({$urandom, $urandom} << (8 * (len + 1)));
      return k;
   endfunction

   function automatic bit [63:0] pick_key();
      int r;
      int p;
      int len;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         p = $urandom_range(0, POOL_SIZE - 1);
         return add_tail(key_pool[p], pool_len[p]);
      end else if (r < 92) begin
         len = $urandom_range(0, 8);
         return add_tail(fresh_string(len), len);
      end
      return {$urandom, $urandom};
   endfunction

   function automatic bit [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic bit [1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return lpht_pkg::FUNC_PUT;
      if (r < 65) return lpht_pkg::FUNC_GET;
      if (r < 95) return lpht_pkg::FUNC_REMOVE;
      return lpht_pkg::FUNC_NONE;
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------

   // Offer one request and hold it until the transfer. Bursts of random length
   // alternate with random gaps; a gap lowers valid and scrambles the payload.
   task automatic send(bit [1:0] func, bit [63:0] key, bit [31:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_func  <= 2'($urandom);
            req_key   <= {$urandom, $urandom};
            req_value <= $urandom;
            repeat (gap) @(posedge clock);
         end
         // Now and then a long stretch with no idling at all
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_key   <= key;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      table_mirror.note_request(func, key, value);
      burst_left--;
   endtask

   // Drop valid and hold off until every outstanding response has come back.
   // Sample on the falling edge so the response side has settled.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (table_mirror.pending() != 0);
      @(posedge clock);
   endtask

   task automatic random_ops(int count);
      for (int i = 0; i < count; i++)
         send(pick_func(), pick_key(), pick_value());
   endtask

   // ---------------------------------------------------------------------------
   // Response side: own stall pattern, plus one long hold on request
   // ---------------------------------------------------------------------------
   initial begin : rsp_side
      int  mode;
      int  mode_left;
      int  hold_left;
      bit  long_hold_done;
      mode           = 0;
      mode_left      = 0;
      hold_left      = 0;
      long_hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            table_mirror.check_response(rsp_ok, rsp_slot, rsp_found_value);
         if (long_hold_req && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            // Refuse responses so the block backs up and stalls its input
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: end the run if neither channel has moved for too long
   // ---------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      table_mirror  = new();
      burst_left    = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_func      <= lpht_pkg::FUNC_PUT;
      req_key       <= '0;
      req_value     <= '0;
      long_hold_req <= 1'b0;

      // Small pool of keys so puts, gets and removes collide and chain
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_len[i] = (i < 2) ? 8 * i : $urandom_range(1, 8);
         key_pool[i] = fresh_string(pool_len[i]);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lookups in an empty table, empty and all-ones keys, value
      // extremes, duplicates, tombstone skip and reuse, junk past the terminator,
      // and the unused operation code.
      send(lpht_pkg::FUNC_GET,    64'h0,                   32'h1234_5678);
      send(lpht_pkg::FUNC_REMOVE, 64'h61,                  32'h0);
      send(lpht_pkg::FUNC_PUT,    64'h0,                   32'h7FFF_FFFF);
      send(lpht_pkg::FUNC_GET,    64'hFFFF_FFFF_FFFF_FF00, 32'h0);
      send(lpht_pkg::FUNC_PUT,    64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
      send(lpht_pkg::FUNC_GET,    64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send(lpht_pkg::FUNC_PUT,    64'h61,                  32'h1);
      send(lpht_pkg::FUNC_PUT,    64'h61,                  32'h2);
      send(lpht_pkg::FUNC_GET,    64'h61,                  32'h0);
      send(lpht_pkg::FUNC_REMOVE, 64'h61,                  32'h0);
      send(lpht_pkg::FUNC_GET,    64'h61,                  32'h0);
      send(lpht_pkg::FUNC_PUT,    64'h61,                  32'h3);
      send(lpht_pkg::FUNC_GET,    64'hDEAD_BEEF_0000_0061, 32'h0);
      send(lpht_pkg::FUNC_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send(lpht_pkg::FUNC_REMOVE, 64'h0,                   32'h0);
      send(lpht_pkg::FUNC_GET,    64'h0,                   32'h0);
      send(lpht_pkg::FUNC_PUT,    64'h0101_0101_0101_0101, 32'h0);
      send(lpht_pkg::FUNC_REMOVE, 64'h0101_0101_0101_0101, 32'h0);
      send(lpht_pkg::FUNC_REMOVE, 64'h0101_0101_0101_0101, 32'h0);
      send(lpht_pkg::FUNC_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
      send(lpht_pkg::FUNC_PUT,    64'h7A7A,                32'hFFFF_FFFF);
      send(lpht_pkg::FUNC_GET,    64'h7A7A,                32'h0);
      drain();

      // Mixed traffic on the key pool
      random_ops(200);
      drain();

      // Fill the table past capacity, then punch tombstones and reuse them
      for (int i = 0; i < FILL_PUTS; i++) begin
         fill_keys[i] = fresh_string($urandom_range(1, 8));
         send(lpht_pkg::FUNC_PUT, fill_keys[i], pick_value());
      end
      for (int i = 0; i < 20; i++)
         send(lpht_pkg::FUNC_GET, fill_keys[$urandom_range(0, FILL_PUTS - 1)],
              pick_value());
      for (int i = 0; i < 40; i++)
         send(lpht_pkg::FUNC_REMOVE, fill_keys[$urandom_range(0, FILL_PUTS - 1)],
              pick_value());
      for (int i = 0; i < 15; i++)
         send(lpht_pkg::FUNC_GET,
              ($urandom_range(0, 1) == 1) ? fill_keys[$urandom_range(0, FILL_PUTS - 1)]
                                          : pick_key(),
              pick_value());
      for (int i = 0; i < 15; i++)
         send(lpht_pkg::FUNC_PUT, pick_key(), pick_value());
      drain();

      // More mixed traffic; partway in, ask the response side for its long hold
      random_ops(20);
      long_hold_req <= 1'b1;
      random_ops(130);
      drain();

      // Let any stray response show up before the verdict
      repeat (SETTLE_TIME) @(posedge clock);
      if (table_mirror.errors == 0 && table_mirror.pending() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

[linear_probe_hash_table_top.f]
+incdir+design
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_ctrl.sv
design/lpht_dp.sv
design/linear_probe_hash_table_top.sv
bench/tb.sv
